// File: rtl/core/huffman_tree_rle_decoder_unit_macros.svh
// Assertion helpers for the checker file.
`ifndef HUFFMAN_TREE_RLE_DECODER_UNIT_MACROS_SVH
`define HUFFMAN_TREE_RLE_DECODER_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define HTRD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("htrd check failed");

// Check a condition in the cycle after its trigger.
`define HTRD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("htrd check failed");

`endif

// File: rtl/core/htrd_pkg.sv
`default_nettype none
package htrd_pkg;

	// Item operation codes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_DATA  = 2'd2;

	// Tree table geometry
	localparam int TREE_NODES = 256;
	localparam int NODE_W     = 8;
	localparam int CHILD_W    = 16;
	localparam int ENTRY_W    = 2 * CHILD_W;

	// Run-length delimiter and the child code for the stop symbol, -(256+1)
	localparam logic [7:0]         RLE_DELIM  = 8'h90;
	localparam logic [CHILD_W-1:0] STOP_CHILD = 16'hFEFF;

	// One result item without its last mark
	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] repeat_count;
		logic       end_of_stream;
		logic       bad_data;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/core/huffman_tree_rle_decoder_unit.sv
`default_nettype none
// Huffman tree walker with run-length expander. A start item (operation 0)
// resets the stream and makes node 0 a stop-only node; load items (operation 1)
// write one tree node each. A data item (operation 2) walks its eight bits,
// least significant first, through the tree table, which sits in one
// synchronous RAM: each bit needs one table read, and the registered read
// data picks the next read address, so a data byte keeps the block busy, and
// takes no new item, until its walk ends and its final result is handed over.
// Results are runs (byte, repeat count) or a status item for the stop symbol
// or bad tree data; the last result of an item carries last. A walk in
// progress continues into the next data byte. Backpressure on the result side
// stalls the walk once the internal result slot and the output register are
// both full.
module huffman_tree_rle_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  node_index,
	input  wire logic [15:0] left_child,
	input  wire logic [15:0] right_child,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic [7:0]       repeat_count,
	output logic             end_of_stream,
	output logic             bad_data,
	output logic             last
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic                                  state_q;
	logic [2:0]                            bit_q;
	logic [7:0]                            data_q;
	logic [htrd_pkg::NODE_W-1:0]           walk_q;
	logic                                  expect_q;
	logic [7:0]                            prev_q;
	logic                                  finished_q;
	logic                                  pend_valid_q;
	htrd_pkg::res_t                        pend_q;
	logic                                  out_valid_q;
	htrd_pkg::res_t                        out_q;
	logic                                  out_last_q;

	logic [htrd_pkg::ENTRY_W-1:0]          entry;
	logic [htrd_pkg::CHILD_W-1:0]          child;
	logic [htrd_pkg::CHILD_W-1:0]          sym;
	logic                                  node_ok;
	logic [htrd_pkg::NODE_W-1:0]           nxt_node;
	logic                                  gen;
	logic                                  fin;
	htrd_pkg::res_t                        res;
	logic                                  nxt_expect;
	logic [7:0]                            prev_nxt;

	logic                                  out_free;
	logic                                  stall;
	logic                                  step;
	logic                                  done;
	logic                                  push_mid;
	logic                                  flush;
	logic                                  accept;
	logic                                  start_walk;

	logic                                  ram_we;
	logic [htrd_pkg::NODE_W-1:0]           ram_waddr;
	logic [htrd_pkg::ENTRY_W-1:0]          ram_wdata;
	logic                                  ram_re;
	logic [htrd_pkg::NODE_W-1:0]           ram_raddr;

	// Tree table
	htrd_ram #(
		.WIDTH(htrd_pkg::ENTRY_W),
		.DEPTH(htrd_pkg::TREE_NODES)
	) u_tree (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(entry)
	);

	// Pick the child for the current bit and decode it
	assign child    = data_q[bit_q] ? entry[31:16] : entry[15:0];
	assign sym      = ~child;
	assign node_ok  = !child[15] && (child[15:8] == 8'd0);
	assign nxt_node = node_ok ? child[7:0] : '0;

	// One walk step: symbol handling and run-length expansion
	always_comb begin
		gen        = 1'b0;
		fin        = 1'b0;
		res        = '0;
		nxt_expect = expect_q;
		prev_nxt   = prev_q;
		if (!child[15]) begin
			if (child[15:8] != 8'd0) begin
				gen          = 1'b1;
				fin          = 1'b1;
				res.bad_data = 1'b1;
			end
		end else if ((sym[14:9] != 6'd0) || (sym[8] && (sym[7:0] != 8'd0))) begin
			gen          = 1'b1;
			fin          = 1'b1;
			res.bad_data = 1'b1;
		end else if (sym[8]) begin
			gen               = 1'b1;
			fin               = 1'b1;
			res.end_of_stream = 1'b1;
			res.bad_data      = expect_q;
			nxt_expect        = 1'b0;
		end else if (expect_q) begin
			nxt_expect = 1'b0;
			if (sym[7:0] == 8'd0) begin
				gen              = 1'b1;
				prev_nxt         = htrd_pkg::RLE_DELIM;
				res.out_byte     = htrd_pkg::RLE_DELIM;
				res.repeat_count = 8'd1;
			end else if (sym[7:0] != 8'd1) begin
				gen              = 1'b1;
				res.out_byte     = prev_q;
				res.repeat_count = sym[7:0] - 8'd1;
			end
		end else if (sym[7:0] == htrd_pkg::RLE_DELIM) begin
			nxt_expect = 1'b1;
		end else begin
			gen              = 1'b1;
			prev_nxt         = sym[7:0];
			res.out_byte     = sym[7:0];
			res.repeat_count = 8'd1;
		end
	end

	// Handshake and sequencing control
	assign out_free   = !out_valid_q || out_ready;
	assign stall      = (state_q == ST_WALK) && gen && pend_valid_q && !out_free;
	assign step       = (state_q == ST_WALK) && !stall;
	assign done       = step && (fin || (bit_q == 3'd7));
	assign push_mid   = step && gen && pend_valid_q;
	assign flush      = (state_q == ST_IDLE) && pend_valid_q && out_free;
	assign in_ready   = (state_q == ST_IDLE) && !pend_valid_q;
	assign accept     = in_valid && in_ready;
	assign start_walk = accept && (operation == htrd_pkg::OP_DATA) && !finished_q;

	// Table port: loads and start write, walk reads
	assign ram_we    = accept && ((operation == htrd_pkg::OP_START) ||
		(operation == htrd_pkg::OP_LOAD));
	assign ram_waddr = (operation == htrd_pkg::OP_START) ? '0 : node_index;
	assign ram_wdata = (operation == htrd_pkg::OP_START) ?
		{htrd_pkg::STOP_CHILD, htrd_pkg::STOP_CHILD} : {right_child, left_child};
	assign ram_re    = start_walk || (step && !done);
	assign ram_raddr = start_walk ? walk_q : nxt_node;

	// Advance the walk and the stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bit_q      <= '0;
			walk_q     <= '0;
			expect_q   <= 1'b0;
			prev_q     <= '0;
			finished_q <= 1'b0;
		end else begin
			if (accept && (operation == htrd_pkg::OP_START)) begin
				walk_q     <= '0;
				expect_q   <= 1'b0;
				prev_q     <= '0;
				finished_q <= 1'b0;
			end
			if (start_walk) begin
				state_q <= ST_WALK;
				bit_q   <= '0;
			end else if (step) begin
				bit_q    <= bit_q + 3'd1;
				walk_q   <= nxt_node;
				expect_q <= nxt_expect;
				prev_q   <= prev_nxt;
				if (fin) begin
					finished_q <= 1'b1;
				end
				if (done) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	// Hold the byte under walk
	always_ff @(posedge clk) begin
		if (start_walk) begin
			data_q <= data_byte;
		end
	end

	// Result slot and output register valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (step && gen) begin
				pend_valid_q <= 1'b1;
			end else if (flush) begin
				pend_valid_q <= 1'b0;
			end
			if (flush || push_mid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payloads; an item's final result leaves on flush
	always_ff @(posedge clk) begin
		if (step && gen) begin
			pend_q <= res;
		end
		if (flush || push_mid) begin
			out_q      <= pend_q;
			out_last_q <= flush;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_q.out_byte;
	assign repeat_count  = out_q.repeat_count;
	assign end_of_stream = out_q.end_of_stream;
	assign bad_data      = out_q.bad_data;
	assign last          = out_last_q;

endmodule
`default_nettype wire

// File: rtl/core/htrd_ram.sv
`default_nettype none
module htrd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register one read; rdata holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/htrd_checker.sv
`default_nettype none
`include "huffman_tree_rle_decoder_unit_macros.svh"
module htrd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  operation,
	input wire logic [7:0]  node_index,
	input wire logic [15:0] left_child,
	input wire logic [15:0] right_child,
	input wire logic [7:0]  data_byte,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  out_byte,
	input wire logic [7:0]  repeat_count,
	input wire logic        end_of_stream,
	input wire logic        bad_data,
	input wire logic        last
);

	// A stalled result item holds
	`HTRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(repeat_count) && $stable(last))

	// Status items end the item and carry no run
	`HTRD_ASSERT_NOW(a_status_final, out_valid && (end_of_stream || bad_data), last && (repeat_count == 8'd0) && (out_byte == 8'd0))

	// Run items always write at least once
	`HTRD_ASSERT_NOW(a_run_nonzero, out_valid && !end_of_stream && !bad_data, repeat_count != 8'd0)

	// More results pending: no new item is taken
	`HTRD_ASSERT_NOW(a_busy_until_last, out_valid && !last, !in_ready)

endmodule

bind huffman_tree_rle_decoder_unit htrd_checker u_htrd_checker (.*);
`default_nettype wire
